>>> design/prf_pkg.sv
// ----------------------------------------------------------------------------
// prf_pkg: shared types and constants
// Beat layouts, operation codes, register addresses and reset image of the
// power-management register file.
// ----------------------------------------------------------------------------
package prf_pkg;

    typedef enum logic [2:0] {
        OP_START  = 3'd0,
        OP_WRITE  = 3'd1,
        OP_READ   = 3'd2,
        OP_GPIN   = 3'd3,
        OP_BUTTON = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic [1:0] line;
        logic       level;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_level;
        logic [2:0] gpo_levels;
    } t_result;

    typedef struct packed {
        logic [7:0]       ptr;
        logic [4:0][7:0]  core;
        logic [2:0][7:0]  conv;
        logic [7:0][7:0]  ldo;
        logic [1:0][7:0]  sleep;
        logic [1:0][7:0]  osc;
        logic [15:0]      mask;
        logic [15:0]      status;
        logic [7:0]       gdir;
        logic [7:0]       gout;
        logic [7:0]       bbsms;
        logic [3:0][7:0]  pull;
        logic [3:0][7:0]  card;
        logic [4:0]       rtc_ctrl;
        logic [15:0]      rtc_comp;
        logic [5:0][7:0]  alarm;
    } t_regs;

    localparam logic [7:0]  C_REV_CODE    = 8'h22;
    localparam logic [4:0]  C_VCORE_CLAMP = 5'h12;
    localparam logic [7:0]  C_DIR_MASK    = 8'h67;
    localparam logic [7:0]  C_BBSMS_VALUE = 8'h0d;
    localparam logic [15:0] C_MASK_RESET  = 16'h0fff;
    localparam int          C_BUTTON_BIT  = 11;
    localparam int          C_TIME_BIT    = 10;
    localparam logic [7:0]  C_HOUR_NEG    = 8'hff;
    localparam logic [2:0]  C_RTC_12H     = 3'd2;

    localparam logic [7:0] A_REV      = 8'h01;
    localparam logic [7:0] A_CORE0    = 8'h02;
    localparam logic [7:0] A_CORE1    = 8'h03;
    localparam logic [7:0] A_CORE2    = 8'h04;
    localparam logic [7:0] A_CORE3    = 8'h05;
    localparam logic [7:0] A_CORE4    = 8'h06;
    localparam logic [7:0] A_CONV0    = 8'h07;
    localparam logic [7:0] A_CONV1    = 8'h08;
    localparam logic [7:0] A_CONV2    = 8'h09;
    localparam logic [7:0] A_LDO0     = 8'h0a;
    localparam logic [7:0] A_LDO1     = 8'h0b;
    localparam logic [7:0] A_LDO2     = 8'h0c;
    localparam logic [7:0] A_LDO3     = 8'h0d;
    localparam logic [7:0] A_LDO4     = 8'h0e;
    localparam logic [7:0] A_LDO5     = 8'h0f;
    localparam logic [7:0] A_LDO6     = 8'h10;
    localparam logic [7:0] A_LDO7     = 8'h11;
    localparam logic [7:0] A_SLEEP0   = 8'h12;
    localparam logic [7:0] A_SLEEP1   = 8'h13;
    localparam logic [7:0] A_DEVOFF   = 8'h14;
    localparam logic [7:0] A_OSC      = 8'h15;
    localparam logic [7:0] A_DETECT   = 8'h16;
    localparam logic [7:0] A_MASK_LO  = 8'h17;
    localparam logic [7:0] A_MASK_HI  = 8'h18;
    localparam logic [7:0] A_STAT_LO  = 8'h19;
    localparam logic [7:0] A_STAT_HI  = 8'h1a;
    localparam logic [7:0] A_ACK_LO   = 8'h1b;
    localparam logic [7:0] A_ACK_HI   = 8'h1c;
    localparam logic [7:0] A_GDIR     = 8'h1d;
    localparam logic [7:0] A_GLEVEL   = 8'h1e;
    localparam logic [7:0] A_GOUT     = 8'h1f;
    localparam logic [7:0] A_BBSMS    = 8'h20;
    localparam logic [7:0] A_RTC_CTRL = 8'h21;
    localparam logic [7:0] A_RTC_UPD  = 8'h22;
    localparam logic [7:0] A_ALM_SEC  = 8'h2a;
    localparam logic [7:0] A_ALM_MIN  = 8'h2b;
    localparam logic [7:0] A_ALM_HR   = 8'h2c;
    localparam logic [7:0] A_ALM_DAY  = 8'h2d;
    localparam logic [7:0] A_ALM_MON  = 8'h2e;
    localparam logic [7:0] A_ALM_YR   = 8'h2f;
    localparam logic [7:0] A_COMP_HI  = 8'h30;
    localparam logic [7:0] A_COMP_LO  = 8'h31;
    localparam logic [7:0] A_PULL0    = 8'h32;
    localparam logic [7:0] A_PULL1    = 8'h33;
    localparam logic [7:0] A_PULL2    = 8'h34;
    localparam logic [7:0] A_PULL3    = 8'h35;
    localparam logic [7:0] A_CARD0    = 8'h36;
    localparam logic [7:0] A_CARD1    = 8'h37;
    localparam logic [7:0] A_CARD2    = 8'h38;
    localparam logic [7:0] A_DEBOUNCE = 8'h3a;

    localparam t_regs C_REGS_RESET = '{
        ptr:      8'h00,
        core:     {8'h03, 8'h0c, 8'h02, 8'h05, 8'h0c},
        conv:     {8'h00, 8'h03, 8'h33},
        ldo:      {8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h7e, 8'h95},
        sleep:    {8'h00, 8'h00},
        osc:      {8'h09, 8'h01},
        mask:     C_MASK_RESET,
        status:   16'h0000,
        gdir:     8'h07,
        gout:     8'h00,
        bbsms:    8'h00,
        pull:     {8'h00, 8'h00, 8'h00, 8'h00},
        card:     {8'h05, 8'h00, 8'hc0, 8'h03},
        rtc_ctrl: 5'h00,
        rtc_comp: 16'h0000,
        alarm:    {8'h04, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00}
    };

endpackage

>>> design/pmic_register_file_i2c.sv
// ----------------------------------------------------------------------------
// pmic_register_file_i2c: power-management register file on a byte bus
//
//   channel  dir  tdata (low bit up)                     tuser
//   s_*      in   data[7:0] line[9:8] level[10]         operation[2:0]
//   m_*      out  read_data[7:0] irq_level[8] gpo[11:9]  -
//
// one beat in gives one beat out; a beat is accepted every cycle while the
// result register is not stalled; each beat passes the input register, then the
// register update into the result register
// reset (i_rst_n low, synchronous) restores all registers, clears both stages
// an m_tready stall holds the result; one more input beat is taken into the
// input register before s_tready drops
// ----------------------------------------------------------------------------
module pmic_register_file_i2c (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data[7:0], line[9:8], level[10], zero fill
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // read_data[7:0], irq_level[8], gpo_levels[11:9], zero
);
    import prf_pkg::*;

    t_item   in_item;
    t_item   st_item;
    logic    st_valid;
    logic    advance;
    t_result core_res;
    t_result out_res;

    assign in_item.op    = s_tuser;
    assign in_item.data  = s_tdata[7:0];
    assign in_item.line  = s_tdata[9:8];
    assign in_item.level = s_tdata[10];

    assign advance = st_valid && (!m_tvalid || m_tready);

    prf_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_tvalid),
        .o_ready   (s_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (st_valid),
        .o_item    (st_item)
    );

    prf_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (st_item),
        .o_result (core_res)
    );

    prf_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (core_res),
        .i_ready  (m_tready),
        .o_valid  (m_tvalid),
        .o_result (out_res)
    );

    assign m_tdata = {4'h0, out_res.gpo_levels, out_res.irq_level, out_res.read_data};

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready && st_valid |-> !s_tready && !advance)
        else $error("beat advanced into a stalled result register");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> m_tvalid)
        else $error("processed beat lost");

endmodule

>>> design/prf_in_stage.sv
// ----------------------------------------------------------------------------
// prf_in_stage: input register
// Holds one accepted beat until the register file can process it.
// ----------------------------------------------------------------------------
module prf_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  prf_pkg::t_item i_item,
    input  logic          i_advance,
    output logic          o_valid,
    output prf_pkg::t_item o_item
);
    import prf_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

>>> design/prf_core.sv
// ----------------------------------------------------------------------------
// prf_core: register state and per-beat update
// Pointer handling, masked and clamped writes, BCD alarm fields, interrupt
// status and gpio levels; one beat is applied per enabled cycle.
// ----------------------------------------------------------------------------
module prf_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  prf_pkg::t_item   i_item,
    output prf_pkg::t_result o_result
);
    import prf_pkg::*;

    t_regs      r_regs;
    t_regs      n_regs;
    logic       r_first;
    logic       n_first;
    logic [2:0] r_gin;
    logic [2:0] n_gin;
    logic       r_button;
    logic       n_button;
    logic [7:0] rd;
    logic [7:0] addr;
    logic [7:0] v;
    logic [7:0] hour;
    logic [7:0] hour_c;
    logic [7:0] mon;
    t_op        op;

    function automatic logic [7:0] bcd_out(input logic [8:0] x);
        logic [16:0] p;
        logic [4:0]  q;
        logic [8:0]  t;
        logic [8:0]  r;
        p = 17'(x) * 17'd205;
        q = p[15:11];
        t = 9'(q) * 9'd10;
        r = x - t;
        return {q[3:0], r[3:0]};
    endfunction

    function automatic logic [7:0] bcd_in(input logic [7:0] x);
        return 8'(x[7:4]) * 8'd10 + 8'(x[3:0]);
    endfunction

    function automatic logic [7:0] hour12(input logic [7:0] h);
        logic [18:0] p;
        logic [4:0]  q;
        logic [7:0]  m;
        p = 19'(h) * 19'd171;
        q = p[15:11];
        m = h - 8'(q) * 8'd12;
        return bcd_out(9'(m) + 9'd1) | ((h >= 8'd12) ? 8'h80 : 8'h00);
    endfunction

    function automatic logic [7:0] vclamp(input logic [7:0] x);
        return (x[4:0] > C_VCORE_CLAMP) ? 8'(C_VCORE_CLAMP) : 8'(x[4:0]);
    endfunction

    assign op   = t_op'(i_item.op);
    assign addr = r_regs.ptr;
    assign v    = i_item.data;

    // register read
    always_comb begin
        case (addr)
            A_REV:      rd = C_REV_CODE;
            A_CORE0:    rd = r_regs.core[0];
            A_CORE1:    rd = r_regs.core[1];
            A_CORE2:    rd = r_regs.core[2];
            A_CORE3:    rd = r_regs.core[3];
            A_CORE4:    rd = r_regs.core[4];
            A_CONV0:    rd = r_regs.conv[0];
            A_CONV1:    rd = r_regs.conv[1];
            A_CONV2:    rd = r_regs.conv[2];
            A_LDO0:     rd = r_regs.ldo[0];
            A_LDO1:     rd = r_regs.ldo[1];
            A_LDO2:     rd = r_regs.ldo[2];
            A_LDO3:     rd = r_regs.ldo[3];
            A_LDO4:     rd = r_regs.ldo[4];
            A_LDO5:     rd = r_regs.ldo[5];
            A_LDO6:     rd = r_regs.ldo[6];
            A_LDO7:     rd = r_regs.ldo[7];
            A_SLEEP0:   rd = r_regs.sleep[0];
            A_SLEEP1:   rd = r_regs.sleep[1];
            A_OSC:      rd = r_regs.osc[0] | 8'h80;
            A_DETECT:   rd = r_regs.osc[1];
            A_MASK_LO:  rd = r_regs.mask[7:0];
            A_MASK_HI:  rd = r_regs.mask[15:8];
            A_STAT_LO:  rd = r_regs.status[7:0];
            A_STAT_HI:  rd = r_regs.status[15:8];
            A_GDIR:     rd = r_regs.gdir;
            A_GLEVEL:   rd = {5'b0, r_gin} | (~r_regs.gdir & r_regs.gout);
            A_GOUT:     rd = r_regs.gout;
            A_BBSMS:    rd = r_regs.bbsms;
            A_RTC_CTRL: rd = 8'(r_regs.rtc_ctrl);
            A_ALM_SEC:  rd = bcd_out(9'(r_regs.alarm[0]));
            A_ALM_MIN:  rd = bcd_out(9'(r_regs.alarm[1]));
            A_ALM_HR: begin
                if (r_regs.rtc_ctrl[C_RTC_12H]) begin
                    rd = (r_regs.alarm[2] == C_HOUR_NEG) ? 8'h00 : hour12(r_regs.alarm[2]);
                end else begin
                    rd = (r_regs.alarm[2] == C_HOUR_NEG) ? C_HOUR_NEG
                                                          : bcd_out(9'(r_regs.alarm[2]));
                end
            end
            A_ALM_DAY:  rd = bcd_out(9'(r_regs.alarm[3]));
            A_ALM_MON:  rd = bcd_out(9'(r_regs.alarm[4]) + 9'd1);
            A_ALM_YR:   rd = bcd_out(9'(r_regs.alarm[5]));
            A_COMP_HI:  rd = r_regs.rtc_comp[15:8];
            A_COMP_LO:  rd = r_regs.rtc_comp[7:0];
            A_PULL0:    rd = r_regs.pull[0];
            A_PULL1:    rd = r_regs.pull[1];
            A_PULL2:    rd = r_regs.pull[2];
            A_PULL3:    rd = r_regs.pull[3];
            A_CARD0:    rd = r_regs.card[0];
            A_CARD1:    rd = r_regs.card[1];
            A_CARD2:    rd = r_regs.card[2];
            A_DEBOUNCE: rd = r_regs.card[3];
            default:    rd = 8'h00;
        endcase
    end

    // alarm hour and month conversion
    always_comb begin
        hour   = bcd_in({2'b00, v[5:0]});
        hour_c = (hour > 8'd12) ? 8'd12 : hour;
        if (r_regs.rtc_ctrl[C_RTC_12H]) begin
            hour = v[7] ? hour_c + 8'd11 : hour_c - 8'd1;
        end
        mon = bcd_in(v);
        mon = (mon == 8'd0) ? 8'd0 : mon - 8'd1;
    end

    // next state
    always_comb begin
        n_regs   = r_regs;
        n_first  = r_first;
        n_gin    = r_gin;
        n_button = r_button;
        case (op)
            OP_START: begin
                n_first = 1'b1;
            end
            OP_WRITE: begin
                if (r_first) begin
                    n_regs.ptr = v;
                    n_first    = 1'b0;
                end else begin
                    n_regs.ptr = r_regs.ptr + 8'd1;
                    case (addr)
                        A_CORE0:    n_regs.core[0] = (v & 8'h0e) | vclamp(v);
                        A_CORE1:    n_regs.core[1] = v;
                        A_CORE2:    n_regs.core[2] = vclamp(v);
                        A_CORE3:    n_regs.core[3] = vclamp(v);
                        A_CORE4:    n_regs.core[4] = v & 8'h03;
                        A_CONV0:    n_regs.conv[0] = v & 8'h3f;
                        A_CONV1:    n_regs.conv[1] = v & 8'h07;
                        A_CONV2:    n_regs.conv[2] = v & 8'h07;
                        A_LDO0:     n_regs.ldo[0] = v;
                        A_LDO1:     n_regs.ldo[1] = v & 8'h7f;
                        A_LDO2:     n_regs.ldo[2] = v & 8'h03;
                        A_LDO3:     n_regs.ldo[3] = v & 8'h03;
                        A_LDO4:     n_regs.ldo[4] = v & 8'h03;
                        A_LDO5:     n_regs.ldo[5] = v & 8'h03;
                        A_LDO6:     n_regs.ldo[6] = v & 8'h03;
                        A_LDO7:     n_regs.ldo[7] = v & 8'h03;
                        A_SLEEP0:   n_regs.sleep[0] = v;
                        A_SLEEP1:   n_regs.sleep[1] = v;
                        A_DEVOFF: begin
                            if (v[0]) begin
                                n_regs = C_REGS_RESET;
                            end
                        end
                        A_OSC:      n_regs.osc[0] = v & 8'h07;
                        A_DETECT:   n_regs.osc[1] = v & 8'h7f;
                        A_MASK_LO:  n_regs.mask = {4'h0, r_regs.mask[11:8], v};
                        A_MASK_HI:  n_regs.mask = {v, r_regs.mask[7:0]};
                        A_ACK_LO:   n_regs.status = r_regs.status & ~{8'h00, v};
                        A_ACK_HI:   n_regs.status = r_regs.status & ~{v, 8'h00};
                        A_GDIR:     n_regs.gdir = v & C_DIR_MASK;
                        A_GOUT:     n_regs.gout = v & 8'h07;
                        A_BBSMS:    n_regs.bbsms = C_BBSMS_VALUE;
                        A_RTC_CTRL: n_regs.rtc_ctrl = v[4:0];
                        A_RTC_UPD: begin
                            if (v[3:0] == 4'd4 || v[3]) begin
                                n_regs.status[C_TIME_BIT] = 1'b1;
                            end
                        end
                        A_ALM_SEC:  n_regs.alarm[0] = bcd_in(v & 8'h7f);
                        A_ALM_MIN:  n_regs.alarm[1] = bcd_in(v & 8'h7f);
                        A_ALM_HR:   n_regs.alarm[2] = hour;
                        A_ALM_DAY:  n_regs.alarm[3] = bcd_in(v);
                        A_ALM_MON:  n_regs.alarm[4] = mon;
                        A_ALM_YR:   n_regs.alarm[5] = bcd_in(v);
                        A_COMP_HI:  n_regs.rtc_comp = {v, r_regs.rtc_comp[7:0]};
                        A_COMP_LO:  n_regs.rtc_comp = {r_regs.rtc_comp[15:8], v};
                        A_PULL0:    n_regs.pull[0] = v;
                        A_PULL1:    n_regs.pull[1] = v & 8'h1f;
                        A_PULL2:    n_regs.pull[2] = v;
                        A_PULL3:    n_regs.pull[3] = v & 8'h1f;
                        A_CARD0:    n_regs.card[0] = v & 8'h7f;
                        A_CARD1:    n_regs.card[1] = v;
                        A_CARD2:    n_regs.card[2] = v & 8'h0f;
                        A_DEBOUNCE: n_regs.card[3] = v & 8'h3f;
                        default:    n_regs.ptr = r_regs.ptr + 8'd1;
                    endcase
                end
            end
            OP_READ: begin
                n_regs.ptr = r_regs.ptr + 8'd1;
            end
            OP_GPIN: begin
                if (i_item.line != 2'd3) begin
                    n_gin[i_item.line] = i_item.level;
                end
            end
            OP_BUTTON: begin
                if (!r_button && i_item.level) begin
                    n_regs.status[C_BUTTON_BIT] = 1'b1;
                end
                n_button = i_item.level;
            end
            default: begin
                n_first = r_first;
            end
        endcase
    end

    always_comb begin
        o_result.read_data  = (op == OP_READ) ? rd : 8'h00;
        o_result.irq_level  = |(n_regs.status & ~n_regs.mask);
        o_result.gpo_levels = n_regs.gout[2:0] & ~n_regs.gdir[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs   <= C_REGS_RESET;
            r_first  <= 1'b0;
            r_gin    <= 3'b000;
            r_button <= 1'b0;
        end else if (i_en) begin
            r_regs   <= n_regs;
            r_first  <= n_first;
            r_gin    <= n_gin;
            r_button <= n_button;
        end
    end

    a_vcore_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_regs.core[2][4:0] <= C_VCORE_CLAMP && r_regs.core[3][4:0] <= C_VCORE_CLAMP)
        else $error("core voltage code above clamp");

    a_devoff_restores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && op == OP_WRITE && !r_first && addr == A_DEVOFF && v[0]
        |=> r_regs == C_REGS_RESET)
        else $error("device off did not restore registers");

    a_read_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && op == OP_READ |=> r_regs.ptr == $past(r_regs.ptr) + 8'd1)
        else $error("pointer did not advance on read");

endmodule

>>> design/prf_out_stage.sv
// ----------------------------------------------------------------------------
// prf_out_stage: result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module prf_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  prf_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_valid,
    output prf_pkg::t_result o_result
);
    import prf_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the power-management register file
// Streams bus starts, pointer loads, register writes and reads, gpio input
// and power-button events into the block. A shadow copy of the register file
// predicts every result beat, which is checked field by field as it leaves.
// Both sides idle at random, the receiver also holds off for long stretches.
// ----------------------------------------------------------------------------
module tb_top;
    import prf_pkg::*;

    localparam int         N_DIRECTED   = 26;
    localparam int         N_RANDOM     = 1800;
    localparam int         CYCLE_LIMIT  = 500000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         HOLD_AT_A    = 300;
    localparam int         HOLD_AT_B    = 1300;
    localparam int         MAX_REPORTS  = 40;
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;
    localparam logic [7:0] ADDR_TOP     = 8'h3f;
    localparam logic [7:0] REV_CODE     = 8'h22;
    localparam logic [4:0] VCORE_MAX    = 5'h12;
    localparam logic [7:0] DIR_BITS     = 8'h67;
    localparam logic [7:0] BBSMS_FIXED  = 8'h0d;
    localparam logic [15:0] MASK_INIT   = 16'h0fff;
    localparam int         BUTTON_BIT   = 11;
    localparam int         TIME_ERR_BIT = 10;
    localparam int         RTC_12H_BIT  = 2;
    localparam int         HOUR_NONE    = 255;
    localparam logic [1:0] GPIN_LINES   = 2'd3;

    typedef struct {
        logic [2:0] op;
        logic [7:0] data;
        logic [1:0] line;
        logic       level;
        int         gap;
        bit         drain;
    } t_bus_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // data[7:0], line[9:8], level[10], zero fill
    logic [2:0]  s_tuser = '0;   // operation[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // read_data[7:0], irq_level[8], gpo_levels[11:9], zero

    t_bus_event stim_q[$];
    t_bus_event cur_ev;
    bit         have_cur = 1'b0;
    t_result    replies_due[$];
    int         n_accepted = 0;
    int         n_checked = 0;
    int         err_count = 0;
    int         rx_wait = 0;
    bit         rx_calm = 1'b0;
    bit         gen_calm = 1'b0;
    bit         gen_armed = 1'b0;
    logic [7:0] gen_ptr = 8'h00;
    int         n_reads = 0;
    int         n_dev_off = 0;
    int         n_edges = 0;
    int         n_holds = 0;
    int         n_drains = 0;

    // shadow register file
    logic [7:0]  sh_ptr;
    logic        sh_armed;
    logic [7:0]  sh_core[5];
    logic [7:0]  sh_conv[3];
    logic [7:0]  sh_ldo[8];
    logic [7:0]  sh_sleep[2];
    logic [7:0]  sh_osc[2];
    logic [15:0] sh_mask;
    logic [15:0] sh_status;
    logic [7:0]  sh_gdir;
    logic [7:0]  sh_gout;
    logic [7:0]  sh_gin;
    logic [7:0]  sh_bbsms;
    logic [7:0]  sh_pull[4];
    logic [7:0]  sh_card[4];
    logic [4:0]  sh_rtc_ctrl;
    logic [15:0] sh_comp;
    logic [7:0]  sh_alarm[6];
    logic        sh_button;

    pmic_register_file_i2c i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [7:0] to_bcd(int v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic int bcd_value(logic [7:0] v);
        return int'(v[7:4]) * 10 + int'(v[3:0]);
    endfunction

    function automatic logic [7:0] vcore_code(logic [7:0] v);
        return (v[4:0] > VCORE_MAX) ? {3'b000, VCORE_MAX} : {3'b000, v[4:0]};
    endfunction

    // device-off image: first-byte flag, gpio inputs and button level survive
    function automatic void shadow_power_on();
        sh_ptr      = 8'h00;
        sh_core     = '{8'h0c, 8'h05, 8'h02, 8'h0c, 8'h03};
        sh_conv     = '{8'h33, 8'h03, 8'h00};
        sh_ldo      = '{8'h95, 8'h7e, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00};
        sh_sleep    = '{8'h00, 8'h00};
        sh_osc      = '{8'h01, 8'h09};
        sh_mask     = MASK_INIT;
        sh_status   = 16'h0000;
        sh_gdir     = 8'h07;
        sh_gout     = 8'h00;
        sh_bbsms    = 8'h00;
        sh_pull     = '{8'h00, 8'h00, 8'h00, 8'h00};
        sh_card     = '{8'h03, 8'hc0, 8'h00, 8'h05};
        sh_rtc_ctrl = 5'h00;
        sh_comp     = 16'h0000;
        sh_alarm    = '{8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd4};
    endfunction

    function automatic t_result apply_bus_event(t_bus_event ev);
        t_result    r;
        logic [7:0] a;
        logic [7:0] v;
        logic [7:0] g;
        int         h;
        r = '0;
        v = ev.data;
        case (ev.op)
            OP_START: sh_armed = 1'b1;
            OP_WRITE: begin
                if (sh_armed) begin
                    sh_ptr   = v;
                    sh_armed = 1'b0;
                end else begin
                    a = sh_ptr;
                    sh_ptr = sh_ptr + 8'd1;
                    case (a)
                        A_CORE0:    sh_core[0] = (v & 8'h0e) | vcore_code(v);
                        A_CORE1:    sh_core[1] = v;
                        A_CORE2:    sh_core[2] = vcore_code(v);
                        A_CORE3:    sh_core[3] = vcore_code(v);
                        A_CORE4:    sh_core[4] = v & 8'h03;
                        A_CONV0:    sh_conv[0] = v & 8'h3f;
                        A_CONV1:    sh_conv[1] = v & 8'h07;
                        A_CONV2:    sh_conv[2] = v & 8'h07;
                        A_LDO0:     sh_ldo[0] = v;
                        A_LDO1:     sh_ldo[1] = v & 8'h7f;
                        A_LDO2, A_LDO3, A_LDO4, A_LDO5, A_LDO6, A_LDO7:
                            sh_ldo[a - A_LDO0] = v & 8'h03;
                        A_SLEEP0:   sh_sleep[0] = v;
                        A_SLEEP1:   sh_sleep[1] = v;
                        A_DEVOFF: begin
                            if (v[0]) begin
                                shadow_power_on();
                                n_dev_off++;
                            end
                        end
                        A_OSC:      sh_osc[0] = v & 8'h07;
                        A_DETECT:   sh_osc[1] = v & 8'h7f;
                        A_MASK_LO:  sh_mask = (sh_mask & 16'h0f00) | {8'h00, v};
                        A_MASK_HI:  sh_mask = (sh_mask & 16'h00ff) | {v, 8'h00};
                        A_ACK_LO:   sh_status = sh_status & ~{8'h00, v};
                        A_ACK_HI:   sh_status = sh_status & ~{v, 8'h00};
                        A_GDIR:     sh_gdir = v & DIR_BITS;
                        A_GOUT:     sh_gout = v & 8'h07;
                        A_BBSMS:    sh_bbsms = BBSMS_FIXED;
                        A_RTC_CTRL: sh_rtc_ctrl = v[4:0];
                        A_RTC_UPD: begin
                            if (v[3:0] == 4'h4 || v[3:0] >= 4'h8)
                                sh_status[TIME_ERR_BIT] = 1'b1;
                        end
                        A_ALM_SEC:  sh_alarm[0] = 8'(bcd_value(v & 8'h7f));
                        A_ALM_MIN:  sh_alarm[1] = 8'(bcd_value(v & 8'h7f));
                        A_ALM_HR: begin
                            h = bcd_value(v & 8'h3f);
                            if (sh_rtc_ctrl[RTC_12H_BIT]) begin
                                if (h > 12) h = 12;
                                h = v[7] ? h + 11 : (h + 255) % 256;
                            end
                            sh_alarm[2] = 8'(h);
                        end
                        A_ALM_DAY:  sh_alarm[3] = 8'(bcd_value(v));
                        A_ALM_MON: begin
                            h = bcd_value(v);
                            sh_alarm[4] = 8'((h < 1 ? 1 : h) - 1);
                        end
                        A_ALM_YR:   sh_alarm[5] = 8'(bcd_value(v));
                        A_COMP_HI:  sh_comp[15:8] = v;
                        A_COMP_LO:  sh_comp[7:0] = v;
                        A_PULL0:    sh_pull[0] = v;
                        A_PULL1:    sh_pull[1] = v & 8'h1f;
                        A_PULL2:    sh_pull[2] = v;
                        A_PULL3:    sh_pull[3] = v & 8'h1f;
                        A_CARD0:    sh_card[0] = v & 8'h7f;
                        A_CARD1:    sh_card[1] = v;
                        A_CARD2:    sh_card[2] = v & 8'h0f;
                        A_DEBOUNCE: sh_card[3] = v & 8'h3f;
                        default: ;
                    endcase
                end
            end
            OP_READ: begin
                a = sh_ptr;
                sh_ptr = sh_ptr + 8'd1;
                n_reads++;
                case (a)
                    A_REV: r.read_data = REV_CODE;
                    A_CORE0, A_CORE1, A_CORE2, A_CORE3, A_CORE4:
                        r.read_data = sh_core[a - A_CORE0];
                    A_CONV0, A_CONV1, A_CONV2:
                        r.read_data = sh_conv[a - A_CONV0];
                    A_LDO0, A_LDO1, A_LDO2, A_LDO3, A_LDO4, A_LDO5, A_LDO6, A_LDO7:
                        r.read_data = sh_ldo[a - A_LDO0];
                    A_SLEEP0, A_SLEEP1:
                        r.read_data = sh_sleep[a - A_SLEEP0];
                    A_OSC:      r.read_data = sh_osc[0] | 8'h80;
                    A_DETECT:   r.read_data = sh_osc[1];
                    A_MASK_LO:  r.read_data = sh_mask[7:0];
                    A_MASK_HI:  r.read_data = sh_mask[15:8];
                    A_STAT_LO:  r.read_data = sh_status[7:0];
                    A_STAT_HI:  r.read_data = sh_status[15:8];
                    A_GDIR:     r.read_data = sh_gdir;
                    A_GLEVEL:   r.read_data = sh_gin | (~sh_gdir & sh_gout);
                    A_GOUT:     r.read_data = sh_gout;
                    A_BBSMS:    r.read_data = sh_bbsms;
                    A_RTC_CTRL: r.read_data = {3'b000, sh_rtc_ctrl};
                    A_ALM_SEC:  r.read_data = to_bcd(sh_alarm[0]);
                    A_ALM_MIN:  r.read_data = to_bcd(sh_alarm[1]);
                    A_ALM_HR: begin
                        h = sh_alarm[2];
                        if (sh_rtc_ctrl[RTC_12H_BIT])
                            r.read_data = (h == HOUR_NONE) ? 8'h00 :
                                to_bcd(h % 12 + 1) | (h >= 12 ? 8'h80 : 8'h00);
                        else
                            r.read_data = (h == HOUR_NONE) ? 8'hff : to_bcd(h);
                    end
                    A_ALM_DAY:  r.read_data = to_bcd(sh_alarm[3]);
                    A_ALM_MON:  r.read_data = to_bcd(int'(sh_alarm[4]) + 1);
                    A_ALM_YR:   r.read_data = to_bcd(sh_alarm[5]);
                    A_COMP_HI:  r.read_data = sh_comp[15:8];
                    A_COMP_LO:  r.read_data = sh_comp[7:0];
                    A_PULL0, A_PULL1, A_PULL2, A_PULL3:
                        r.read_data = sh_pull[a - A_PULL0];
                    A_CARD0, A_CARD1, A_CARD2:
                        r.read_data = sh_card[a - A_CARD0];
                    A_DEBOUNCE: r.read_data = sh_card[3];
                    default:    r.read_data = 8'h00;
                endcase
            end
            OP_GPIN: begin
                if (ev.line < GPIN_LINES) sh_gin[ev.line] = ev.level;
            end
            OP_BUTTON: begin
                if (!sh_button && ev.level) begin
                    sh_status[BUTTON_BIT] = 1'b1;
                    n_edges++;
                end
                sh_button = ev.level;
            end
            default: ;
        endcase
        g = sh_gout & ~sh_gdir;
        r.irq_level  = |(sh_status & ~sh_mask);
        r.gpo_levels = g[2:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int beat, int got, int want);
        if (err_count < MAX_REPORTS)
            $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", beat, what, got, want);
        err_count++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            2: return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            3: return 8'($urandom_range(0, 31));
            default: return 8'($urandom);
        endcase
    endfunction

    // keep device-off resets occasional so the register file gets deep
    function automatic logic [7:0] pick_write_data();
        if (!gen_armed && gen_ptr == A_DEVOFF && $urandom_range(0, 7) != 0)
            return pick_byte() & 8'hfe;
        return pick_byte();
    endfunction

    task automatic push_event(logic [2:0] op, logic [7:0] data,
                              logic [1:0] line = 2'd0, logic level = 1'b0);
        t_bus_event ev;
        ev.op    = op;
        ev.data  = data;
        ev.line  = line;
        ev.level = level;
        if (stim_q.size() % 40 == 0) gen_calm = ($urandom_range(0, 3) == 0);
        ev.gap   = gen_calm ? 0 : $urandom_range(0, 11);
        ev.drain = (stim_q.size() == 700 || stim_q.size() == 1400);
        if (ev.drain) n_drains++;
        case (op)
            OP_START: gen_armed = 1'b1;
            OP_WRITE: begin
                if (gen_armed) begin
                    gen_ptr   = data;
                    gen_armed = 1'b0;
                end else if (gen_ptr == A_DEVOFF && data[0]) begin
                    gen_ptr = 8'h00;
                end else begin
                    gen_ptr = gen_ptr + 8'd1;
                end
            end
            OP_READ: gen_ptr = gen_ptr + 8'd1;
            default: ;
        endcase
        stim_q.push_back(ev);
    endtask

    // driver
    always @(posedge i_clk) begin
        bit took;
        bit offer;
        if (!i_rst_n) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= '0;
            have_cur  = 1'b0;
            sh_armed  = 1'b0;
            sh_gin    = 8'h00;
            sh_button = 1'b0;
            shadow_power_on();
        end else begin
            took = s_tvalid && s_tready;
            if (took) begin
                replies_due.push_back(apply_bus_event(cur_ev));
                n_accepted <= n_accepted + 1;
                have_cur = 1'b0;
            end
            offer = s_tvalid && !took;
            if (!offer && !have_cur && stim_q.size() > 0) begin
                cur_ev   = stim_q.pop_front();
                have_cur = 1'b1;
            end
            if (!offer && have_cur) begin
                if (cur_ev.gap > 0)
                    cur_ev.gap--;
                else if (!cur_ev.drain || n_accepted + int'(took) == n_checked)
                    offer = 1'b1;
            end
            s_tvalid <= offer;
            if (offer) begin
                s_tdata <= {5'd0, cur_ev.level, cur_ev.line, cur_ev.data};
                s_tuser <= cur_ev.op;
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_wait  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.read_data  = m_tdata[7:0];
                seen.irq_level  = m_tdata[8];
                seen.gpo_levels = m_tdata[11:9];
                if (replies_due.size() == 0) begin
                    report_mismatch("beat with nothing expected", n_checked, m_tdata, 0);
                end else begin
                    want = replies_due.pop_front();
                    if (seen.read_data != want.read_data)
                        report_mismatch("read_data", n_checked, seen.read_data,
                                        want.read_data);
                    if (seen.irq_level != want.irq_level)
                        report_mismatch("irq_level", n_checked, seen.irq_level,
                                        want.irq_level);
                    if (seen.gpo_levels != want.gpo_levels)
                        report_mismatch("gpo_levels", n_checked, seen.gpo_levels,
                                        want.gpo_levels);
                end
                n_checked <= n_checked + 1;
                if ((n_checked + 1) % 50 == 0) rx_calm = ($urandom_range(0, 2) == 0);
                rx_wait = rx_calm ? 0 : $urandom_range(0, 11);
                if (n_checked + 1 == HOLD_AT_A || n_checked + 1 == HOLD_AT_B) begin
                    rx_wait = HOLD_CYCLES;
                    n_holds++;
                end
            end
            if (rx_wait > 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int         kind;
        int         n;
        logic [7:0] addr;

        push_event(OP_READ, 8'h00);
        push_event(OP_START, 8'hff);
        push_event(OP_WRITE, A_CORE0);
        push_event(OP_WRITE, 8'hff);
        push_event(OP_WRITE, 8'h00);
        // 12-hour mode, then a time update that flags an error
        push_event(OP_START, 8'h00);
        push_event(OP_WRITE, A_RTC_CTRL);
        push_event(OP_WRITE, 8'h04);
        push_event(OP_WRITE, 8'h09);
        // alarm hour, am zero, read back in 12-hour mode
        push_event(OP_START, 8'h00);
        push_event(OP_WRITE, A_ALM_HR);
        push_event(OP_WRITE, 8'h00);
        push_event(OP_START, 8'h00);
        push_event(OP_WRITE, A_ALM_HR);
        push_event(OP_READ, 8'h00);
        push_event(OP_BUTTON, 8'h00, 2'd0, 1'b1);
        // unmask everything, low byte first
        push_event(OP_START, 8'h00);
        push_event(OP_WRITE, A_MASK_LO);
        push_event(OP_WRITE, 8'h00);
        push_event(OP_WRITE, 8'h00);
        push_event(OP_GPIN, 8'h00, 2'd2, 1'b1);
        push_event(OP_GPIN, 8'h00, 2'd3, 1'b1);
        push_event(OP_SPARE_HI, 8'hff, 2'd3, 1'b1);
        push_event(OP_START, 8'h00);
        push_event(OP_WRITE, A_DEVOFF);
        push_event(OP_WRITE, 8'h01);

        while (stim_q.size() < N_DIRECTED + N_RANDOM) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                push_event(OP_START, pick_byte());
                addr = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                   : 8'($urandom_range(0, ADDR_TOP));
                push_event(OP_WRITE, addr);
                n = $urandom_range(1, 6);
                if (kind < 60) begin
                    repeat (n) begin
                        if ($urandom_range(0, 4) < 3) push_event(OP_WRITE, pick_write_data());
                        else push_event(OP_READ, pick_byte());
                    end
                end else begin
                    repeat (n) push_event(OP_READ, pick_byte());
                end
            end else if (kind < 85) begin
                push_event(OP_GPIN, pick_byte(), 2'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)));
            end else if (kind < 92) begin
                push_event(OP_BUTTON, pick_byte(), 2'($urandom), 1'($urandom));
            end else begin
                case ($urandom_range(0, 3))
                    0: push_event(OP_WRITE, pick_write_data());
                    1: push_event(OP_READ, pick_byte());
                    2: push_event(OP_START, pick_byte());
                    default: push_event(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                                        8'($urandom), 2'($urandom), 1'($urandom));
                endcase
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (stim_q.size() != 0 || have_cur || s_tvalid || n_accepted != n_checked);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (replies_due.size() != 0)
            report_mismatch("results never arrived", n_checked, replies_due.size(), 0);

        $display("covered %0d bus events: %0d reads, %0d device-off resets, %0d button edges",
                 n_accepted, n_reads, n_dev_off, n_edges);
        $display("receiver held off %0d times, sender drained the pipe %0d times",
                 n_holds, n_drains);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
